>>> src/swfs_pkg.sv
// ---------------------------------------------------------------------------
// swfs_pkg
// Shared types and constants of the stop-and-wait frame sender.
// ---------------------------------------------------------------------------
package swfs_pkg;

	// frame layout
	localparam int FRAME_HDR      = 3;
	localparam int FRAME_MAX      = 64;
	localparam int SEND_LEN_W     = 6;
	localparam int PAYLOAD_IDX_W  = 6;
	localparam int CNT_W          = 6;
	localparam logic [SEND_LEN_W-1:0] LEN_LIMIT =
		SEND_LEN_W'(FRAME_MAX - FRAME_HDR);

	// store size default
	localparam int PAYLOAD_DEPTH_DEF = 64;

	// shortest reply that is not ignored
	localparam logic [6:0] RX_MIN_LEN = 7'(FRAME_HDR);

	// saturation value of the tick counter
	localparam logic [15:0] TICKS_SAT = 16'hFFFF;

	// configuration register indexes
	localparam logic [1:0] CFG_ACK_TYPE     = 2'd0;
	localparam logic [1:0] CFG_ACK_TIMEOUT  = 2'd1;
	localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd2;
	localparam logic [1:0] CFG_MAX_LEN      = 2'd3;

	// configuration reset values
	localparam logic [7:0]  ACK_TYPE_RST     = 8'd0;
	localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd2000;
	localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd5;
	localparam logic [5:0]  MAX_LEN_RST      = 6'd50;

	// input item modes
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_RX    = 2'd3;

	// result kinds
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_OUTCOME = 1'b1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  payload_index;
		logic [7:0]  payload_byte;
		logic [7:0]  pkt_type;
		logic [15:0] pkt_seq;
		logic [7:0]  req_len;
		logic [7:0]  rx_type;
		logic [15:0] rx_seq;
		logic [6:0]  rx_length;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic       tx_last;
		logic       success;
	} out_item_t;

	// command from the control to the frame generator
	typedef struct packed {
		logic start_frame;
		logic start_outcome;
		logic ok;
	} gen_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_WAIT
	} state_t;

endpackage

>>> src/stop_and_wait_frame_sender.sv
// ---------------------------------------------------------------------------
// stop_and_wait_frame_sender
// Stop-and-wait sender: loads payload bytes, sends a framed packet, waits
// for an acknowledgement and resends on timeout or a wrong reply.
// ---------------------------------------------------------------------------
//  channel   signals                         direction
//  in        in_valid, in_ready, in_data     request items (load/start/tick/rx)
//  out       out_valid, out_ready, out_data  frame bytes and outcome items
//  cfg       cfg_en, cfg_addr, cfg_data      register writes, no wait
//
//  A frame of 3 + len bytes leaves at one byte per cycle once started, while
//  out_ready holds high, so a start or resend holds the input until its
//  last byte through the single result port has left the request stage.
//  An outcome holds it until it leaves that stage; other items do not. in_ready
//  drops while the frame generator still holds work; a stalled out_ready stalls
//  the walk. Reset clears control and configuration; the store is not cleared.
// ---------------------------------------------------------------------------
module stop_and_wait_frame_sender #(
	parameter int PAYLOAD_DEPTH = swfs_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  swfs_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output swfs_pkg::out_item_t  out_data,
	input  logic                 cfg_en,
	input  logic [1:0]           cfg_addr,
	input  logic [15:0]          cfg_data
);

	localparam int AW      = $clog2(PAYLOAD_DEPTH);
	localparam int IDX_CNT = 2 ** swfs_pkg::PAYLOAD_IDX_W;

	typedef logic [AW-1:0] idx_tbl_t [IDX_CNT];

	// load index folded into the store depth
	function automatic idx_tbl_t build_idx_tbl();
		idx_tbl_t t;
		for (int i = 0; i < IDX_CNT; i++) begin
			t[i] = AW'(i % PAYLOAD_DEPTH);
		end
		return t;
	endfunction

	localparam idx_tbl_t IDX_TBL = build_idx_tbl();

	logic [7:0]                           ack_type_q;
	logic [15:0]                          ack_timeout_q;
	logic [7:0]                           max_attempts_q;
	logic [5:0]                           max_len_q;

	swfs_pkg::state_t                     state_q, state_d;
	logic [7:0]                           held_type_q;
	logic [15:0]                          held_seq_q;
	logic [swfs_pkg::SEND_LEN_W-1:0]      held_len_q;
	logic [7:0]                           attempts_q, attempts_d;
	logic [15:0]                          ticks_q, ticks_d;

	logic                                 in_fire;
	logic                                 gen_busy;
	swfs_pkg::gen_cmd_t                   cmd;
	logic                                 latch_start;
	logic                                 ram_we;
	logic                                 ram_re;
	logic [AW-1:0]                        ram_raddr;
	logic [7:0]                           ram_rdata;

	logic [5:0]                           len_lim;
	logic [5:0]                           len_clip;
	logic [15:0]                          tick_limit;
	logic [15:0]                          ticks_inc;
	logic                                 can_resend;

	assign in_ready = !gen_busy;
	assign in_fire  = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_type_q     <= swfs_pkg::ACK_TYPE_RST;
			ack_timeout_q  <= swfs_pkg::ACK_TIMEOUT_RST;
			max_attempts_q <= swfs_pkg::MAX_ATTEMPTS_RST;
			max_len_q      <= swfs_pkg::MAX_LEN_RST;
		end else if (cfg_en) begin
			unique case (cfg_addr)
				swfs_pkg::CFG_ACK_TYPE:     ack_type_q     <= cfg_data[7:0];
				swfs_pkg::CFG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_data;
				swfs_pkg::CFG_MAX_ATTEMPTS: max_attempts_q <= cfg_data[7:0];
				swfs_pkg::CFG_MAX_LEN:      max_len_q      <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// length clip and tick limit
	assign len_lim    = (max_len_q > swfs_pkg::LEN_LIMIT) ? swfs_pkg::LEN_LIMIT : max_len_q;
	assign len_clip   = (in_data.req_len > {2'b00, len_lim}) ? len_lim
	                    : in_data.req_len[5:0];
	assign tick_limit = (ack_timeout_q == 16'd0) ? 16'd1 : ack_timeout_q;
	assign ticks_inc  = (ticks_q == swfs_pkg::TICKS_SAT) ? ticks_q : ticks_q + 16'd1;
	assign can_resend = (attempts_q < max_attempts_q);

	// control state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= swfs_pkg::ST_IDLE;
			attempts_q <= '0;
			ticks_q    <= '0;
		end else begin
			state_q    <= state_d;
			attempts_q <= attempts_d;
			ticks_q    <= ticks_d;
		end
	end

	// held frame fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_type_q <= '0;
			held_seq_q  <= '0;
			held_len_q  <= '0;
		end else if (latch_start) begin
			held_type_q <= in_data.pkt_type;
			held_seq_q  <= in_data.pkt_seq;
			held_len_q  <= len_clip;
		end
	end

	// decision on each accepted item
	always_comb begin
		state_d           = state_q;
		attempts_d        = attempts_q;
		ticks_d           = ticks_q;
		cmd.start_frame   = 1'b0;
		cmd.start_outcome = 1'b0;
		cmd.ok            = 1'b0;
		latch_start       = 1'b0;
		ram_we            = 1'b0;
		if (in_fire) begin
			unique case (state_q)
				swfs_pkg::ST_IDLE: begin
					unique case (in_data.mode)
						swfs_pkg::MODE_LOAD: ram_we = 1'b1;
						swfs_pkg::MODE_START: begin
							latch_start = 1'b1;
							ticks_d     = '0;
							if (max_attempts_q == 8'd0) begin
								attempts_d        = '0;
								cmd.start_outcome = 1'b1;
							end else begin
								attempts_d      = 8'd1;
								cmd.start_frame = 1'b1;
								state_d         = swfs_pkg::ST_WAIT;
							end
						end
						default: ;
					endcase
				end
				swfs_pkg::ST_WAIT: begin
					unique case (in_data.mode)
						swfs_pkg::MODE_TICK: begin
							ticks_d = ticks_inc;
							if (ticks_inc >= tick_limit) begin
								if (can_resend) begin
									attempts_d      = attempts_q + 8'd1;
									ticks_d         = '0;
									cmd.start_frame = 1'b1;
								end else begin
									cmd.start_outcome = 1'b1;
									state_d           = swfs_pkg::ST_IDLE;
								end
							end
						end
						swfs_pkg::MODE_RX: begin
							if (in_data.rx_length >= swfs_pkg::RX_MIN_LEN) begin
								if (in_data.rx_type == ack_type_q &&
								    in_data.rx_seq == held_seq_q) begin
									cmd.start_outcome = 1'b1;
									cmd.ok            = 1'b1;
									state_d           = swfs_pkg::ST_IDLE;
								end else if (can_resend) begin
									attempts_d      = attempts_q + 8'd1;
									ticks_d         = '0;
									cmd.start_frame = 1'b1;
								end else begin
									cmd.start_outcome = 1'b1;
									state_d           = swfs_pkg::ST_IDLE;
								end
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// payload store
	swfs_payload_ram #(
		.DEPTH (PAYLOAD_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_TBL[in_data.payload_index]),
		.wdata (in_data.payload_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// frame and outcome emission
	swfs_frame_gen #(
		.DEPTH (PAYLOAD_DEPTH),
		.AW    (AW)
	) u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.held_type (held_type_q),
		.held_seq  (held_seq_q),
		.held_len  (held_len_q),
		.busy      (gen_busy),
		.re        (ram_re),
		.raddr     (ram_raddr),
		.rdata     (ram_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> src/swfs_payload_ram.sv
// ---------------------------------------------------------------------------
// swfs_payload_ram
// Payload byte store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module swfs_payload_ram #(
	parameter int DEPTH = swfs_pkg::PAYLOAD_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/swfs_frame_gen.sv
// ---------------------------------------------------------------------------
// swfs_frame_gen
// Walks a frame out byte by byte (header from the held fields, payload from
// the store) or emits an outcome item, through a request stage and an
// output register.
// ---------------------------------------------------------------------------
module swfs_frame_gen #(
	parameter int DEPTH = swfs_pkg::PAYLOAD_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  swfs_pkg::gen_cmd_t                    cmd,
	input  logic [7:0]                            held_type,
	input  logic [15:0]                           held_seq,
	input  logic [swfs_pkg::SEND_LEN_W-1:0]       held_len,
	output logic                                  busy,
	output logic                                  re,
	output logic [AW-1:0]                         raddr,
	input  logic [7:0]                            rdata,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output swfs_pkg::out_item_t                   out_data
);

	logic                            active_q;
	logic                            done_q;
	logic                            ok_q;
	logic [swfs_pkg::CNT_W-1:0]      cnt_q;
	logic [AW-1:0]                   ptr_q;
	logic [swfs_pkg::CNT_W-1:0]      last_idx;

	logic                            valid_s1;
	logic                            kind_s1;
	logic [7:0]                      byte_s1;
	logic                            from_ram_s1;
	logic                            last_s1;
	logic                            ok_s1;

	logic                            out_valid_q;
	swfs_pkg::out_item_t             out_q;

	logic                            move_s1;
	logic                            adv_s1;
	logic                            issue_byte;
	logic                            issue_done;
	logic                            is_last;
	logic [7:0]                      hdr_byte;

	// stage handshakes
	assign move_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign adv_s1     = !valid_s1 || move_s1;
	assign issue_byte = adv_s1 && active_q;
	assign issue_done = adv_s1 && done_q && !active_q;
	assign last_idx   = swfs_pkg::CNT_W'(held_len) + swfs_pkg::CNT_W'(swfs_pkg::FRAME_HDR - 1);
	assign is_last    = (cnt_q == last_idx);

	assign busy = active_q || done_q || valid_s1;

	// header byte select
	always_comb begin
		case (cnt_q)
			swfs_pkg::CNT_W'(0): hdr_byte = held_type;
			swfs_pkg::CNT_W'(1): hdr_byte = held_seq[15:8];
			default:             hdr_byte = held_seq[7:0];
		endcase
	end

	// store read for payload positions
	assign re    = issue_byte && (cnt_q >= swfs_pkg::CNT_W'(swfs_pkg::FRAME_HDR));
	assign raddr = ptr_q;

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			ok_q     <= 1'b0;
			cnt_q    <= '0;
			ptr_q    <= '0;
		end else begin
			if (cmd.start_frame) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
				ptr_q    <= '0;
			end else if (issue_byte) begin
				cnt_q <= cnt_q + swfs_pkg::CNT_W'(1);
				if (is_last) begin
					active_q <= 1'b0;
				end
				if (re) begin
					ptr_q <= (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);
				end
			end
			if (cmd.start_outcome) begin
				done_q <= 1'b1;
				ok_q   <= cmd.ok;
			end else if (issue_done) begin
				done_q <= 1'b0;
			end
		end
	end

	// request stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= issue_byte || issue_done;
		end
	end

	// request stage payload
	always_ff @(posedge clk) begin
		if (issue_byte) begin
			kind_s1     <= swfs_pkg::KIND_BYTE;
			byte_s1     <= hdr_byte;
			from_ram_s1 <= re;
			last_s1     <= is_last;
			ok_s1       <= 1'b0;
		end else if (issue_done) begin
			kind_s1     <= swfs_pkg::KIND_OUTCOME;
			byte_s1     <= '0;
			from_ram_s1 <= 1'b0;
			last_s1     <= 1'b0;
			ok_s1       <= ok_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_q.kind    <= kind_s1;
			out_q.tx_byte <= from_ram_s1 ? rdata : byte_s1;
			out_q.tx_last <= last_s1;
			out_q.success <= ok_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> verif/stop_and_wait_frame_sender_test.sv
// ---------------------------------------------------------------------------
// stop_and_wait_frame_sender_test
// Self-checking bench for the stop-and-wait frame sender. Fills the payload
// store, runs directed exchanges over the register extremes (clipping, zero
// attempts, zero timeout, short and wrong replies, ignored items), then
// random exchanges under several settings. A behavioral copy of the sender
// predicts every frame byte and outcome, and the output is checked in order.
// ---------------------------------------------------------------------------
module stop_and_wait_frame_sender_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH  = swfs_pkg::PAYLOAD_DEPTH_DEF;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_ITEMS = 84;
	localparam int RANDOM_PHASES = 4;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	swfs_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	swfs_pkg::out_item_t out_data;
	logic                cfg_en;
	logic [1:0]          cfg_addr;
	logic [15:0]         cfg_data;

	stop_and_wait_frame_sender #(
		.PAYLOAD_DEPTH(STORE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_en   (cfg_en),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	// register image
	logic [7:0]  reg_ack_type;
	logic [15:0] reg_timeout;
	logic [7:0]  reg_max_tries;
	logic [5:0]  reg_max_len;

	// sender image
	bit          sender_busy;
	logic [7:0]  store_image [STORE_DEPTH];
	logic [7:0]  frame_type;
	logic [15:0] frame_seq;
	logic [5:0]  frame_len;
	logic [7:0]  tries_done;
	logic [15:0] ticks_waited;

	// frame bytes and outcomes still owed by the sender
	swfs_pkg::out_item_t tx_due [$];

	int  errors       = 0;
	int  cycle_count  = 0;
	int  items_sent   = 0;
	int  live_items   = 0;
	int  frames_seen  = 0;
	int  outcomes_seen = 0;
	int  acks_seen    = 0;
	bit  steady_flow  = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sender prediction
	// ------------------------------------------------------------------
	function automatic void reset_sender_image();
		reg_ack_type  = swfs_pkg::ACK_TYPE_RST;
		reg_timeout   = swfs_pkg::ACK_TIMEOUT_RST;
		reg_max_tries = swfs_pkg::MAX_ATTEMPTS_RST;
		reg_max_len   = swfs_pkg::MAX_LEN_RST;
		sender_busy   = 1'b0;
		frame_type    = '0;
		frame_seq     = '0;
		frame_len     = '0;
		tries_done    = '0;
		ticks_waited  = '0;
	endfunction

	// header bytes, then payload, last byte marked
	function automatic void push_frame();
		int         total;
		logic [7:0] b;
		total = swfs_pkg::FRAME_HDR + frame_len;
		for (int i = 0; i < total; i++) begin
			if (i == 0)
				b = frame_type;
			else if (i == 1)
				b = frame_seq[15:8];
			else if (i == 2)
				b = frame_seq[7:0];
			else
				b = store_image[(i - swfs_pkg::FRAME_HDR) % STORE_DEPTH];
			tx_due.push_back('{kind: swfs_pkg::KIND_BYTE, tx_byte: b,
				tx_last: (i == total - 1), success: 1'b0});
		end
	endfunction

	function automatic void push_outcome(logic ok);
		sender_busy = 1'b0;
		tx_due.push_back('{kind: swfs_pkg::KIND_OUTCOME, tx_byte: 8'h00, tx_last: 1'b0,
			success: ok});
	endfunction

	function automatic void resend_or_give_up();
		if (tries_done >= reg_max_tries) begin
			push_outcome(1'b0);
		end else begin
			tries_done++;
			ticks_waited = '0;
			push_frame();
		end
	endfunction

	// returns 1 when the item changes the sender at all
	function automatic bit sender_response(swfs_pkg::in_item_t it);
		logic [5:0]  len_cap;
		logic [15:0] limit;
		case (it.mode)
			swfs_pkg::MODE_LOAD: begin
				if (sender_busy)
					return 1'b0;
				store_image[it.payload_index] = it.payload_byte;
				return 1'b1;
			end
			swfs_pkg::MODE_START: begin
				if (sender_busy)
					return 1'b0;
				len_cap = (reg_max_len > swfs_pkg::LEN_LIMIT) ? swfs_pkg::LEN_LIMIT
				          : reg_max_len;
				frame_type = it.pkt_type;
				frame_seq  = it.pkt_seq;
				frame_len  = (it.req_len > len_cap) ? len_cap : it.req_len[5:0];
				ticks_waited = '0;
				if (reg_max_tries == 0) begin
					tries_done = '0;
					push_outcome(1'b0);
					return 1'b1;
				end
				sender_busy = 1'b1;
				tries_done  = 8'd1;
				push_frame();
				return 1'b1;
			end
			swfs_pkg::MODE_TICK: begin
				if (!sender_busy)
					return 1'b0;
				limit = (reg_timeout == 0) ? 16'd1 : reg_timeout;
				if (ticks_waited != swfs_pkg::TICKS_SAT)
					ticks_waited++;
				if (ticks_waited >= limit)
					resend_or_give_up();
				return 1'b1;
			end
			default: begin
				if (!sender_busy || it.rx_length < swfs_pkg::RX_MIN_LEN)
					return 1'b0;
				if (it.rx_type == reg_ack_type && it.rx_seq == frame_seq)
					push_outcome(1'b1);
				else
					resend_or_give_up();
				return 1'b1;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// item builders, unused fields random
	// ------------------------------------------------------------------
	function automatic swfs_pkg::in_item_t random_item();
		swfs_pkg::in_item_t it;
		it.mode          = 2'($urandom_range(0, 3));
		it.payload_index = 6'($urandom);
		it.payload_byte  = 8'($urandom);
		it.pkt_type      = 8'($urandom);
		it.pkt_seq       = 16'($urandom);
		it.req_len       = 8'($urandom);
		it.rx_type       = 8'($urandom);
		it.rx_seq        = 16'($urandom);
		it.rx_length     = 7'($urandom_range(0, 64));
		return it;
	endfunction

	function automatic swfs_pkg::in_item_t load_item(logic [5:0] idx, logic [7:0] val);
		swfs_pkg::in_item_t it;
		it = random_item();
		it.mode          = swfs_pkg::MODE_LOAD;
		it.payload_index = idx;
		it.payload_byte  = val;
		return it;
	endfunction

	function automatic swfs_pkg::in_item_t start_item(logic [7:0] t, logic [15:0] s,
		logic [7:0] n);
		swfs_pkg::in_item_t it;
		it = random_item();
		it.mode    = swfs_pkg::MODE_START;
		it.pkt_type = t;
		it.pkt_seq  = s;
		it.req_len  = n;
		return it;
	endfunction

	function automatic swfs_pkg::in_item_t tick_item();
		swfs_pkg::in_item_t it;
		it = random_item();
		it.mode = swfs_pkg::MODE_TICK;
		return it;
	endfunction

	function automatic swfs_pkg::in_item_t rx_item(logic [7:0] t, logic [15:0] s,
		logic [6:0] n);
		swfs_pkg::in_item_t it;
		it = random_item();
		it.mode      = swfs_pkg::MODE_RX;
		it.rx_type   = t;
		it.rx_seq    = s;
		it.rx_length = n;
		return it;
	endfunction

	function automatic swfs_pkg::in_item_t ack_item();
		return rx_item(reg_ack_type, frame_seq, 7'($urandom_range(3, 64)));
	endfunction

	// reply of at least the minimum length that must not match: wrong type, wrong sequence or both
	function automatic swfs_pkg::in_item_t wrong_reply();
		swfs_pkg::in_item_t it;
		it = rx_item(8'($urandom), 16'($urandom), 7'($urandom_range(3, 64)));
		case ($urandom_range(0, 2))
			0: it.rx_type = reg_ack_type;
			1: it.rx_seq = frame_seq;
			default: ;
		endcase
		if (it.rx_type == reg_ack_type && it.rx_seq == frame_seq)
			it.rx_seq = frame_seq ^ (16'd1 << $urandom_range(0, 15));
		return it;
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	// hold one item until accepted, then maybe leave a gap
	task automatic send_item(input swfs_pkg::in_item_t it);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_ready !== 1'b1);
		items_sent++;
		if (sender_response(it))
			live_items++;
		if (!steady_flow && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic hold_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_results();
		hold_input();
		while (tx_due.size() != 0)
			@(posedge clk);
	endtask

	// nothing owed and the frame walker surely done
	task automatic quiesce();
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(input logic [1:0] addr, input logic [15:0] value);
		@(negedge clk);
		cfg_en   <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= value;
		case (addr)
			swfs_pkg::CFG_ACK_TYPE:     reg_ack_type  = value[7:0];
			swfs_pkg::CFG_ACK_TIMEOUT:  reg_timeout   = value;
			swfs_pkg::CFG_MAX_ATTEMPTS: reg_max_tries = value[7:0];
			default:                    reg_max_len   = value[5:0];
		endcase
		@(negedge clk);
		cfg_en <= 1'b0;
	endtask

	// output pacing: ready bursts and stalls, always ready once flow is steady
	initial begin : out_pacing
		int burst;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (steady_flow || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				burst = $urandom_range(1, 30);
			end else begin
				out_ready <= 1'b0;
				burst = $urandom_range(1, 19);
			end
			repeat (burst - 1) @(negedge clk);
		end
	end

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			errors++;
		end
	endfunction

	// capture at the rising edge, compare once the same edge's item is predicted
	initial begin : tx_checker
		swfs_pkg::out_item_t got;
		swfs_pkg::out_item_t want;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				got = out_data;
				@(negedge clk);
				if (tx_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %b byte %h",
						$time, got.kind, got.tx_byte);
					errors++;
				end else begin
					want = tx_due.pop_front();
					compare_field("kind", 8'(want.kind), 8'(got.kind));
					compare_field("tx_byte", want.tx_byte, got.tx_byte);
					compare_field("tx_last", 8'(want.tx_last), 8'(got.tx_last));
					compare_field("success", 8'(want.success), 8'(got.success));
				end
				if (got.kind == swfs_pkg::KIND_OUTCOME) begin
					outcomes_seen++;
					if (got.success)
						acks_seen++;
				end else if (got.tx_last) begin
					frames_seen++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// every store entry written, extremes at the ends
	task automatic test_store_fill();
		logic [7:0] val;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			val = (i == 0) ? 8'h00 : (i == STORE_DEPTH - 1) ? 8'hFF : 8'($urandom);
			send_item(load_item(6'(i), val));
		end
	endtask

	// reset settings: clipping, ignored items, short and wrong replies
	task automatic test_reset_settings();
		send_item(start_item(8'hFF, 16'hFFFF, 8'd0));
		send_item(rx_item(reg_ack_type, frame_seq, 7'd64));
		// longest request clipped to the reset limit
		send_item(start_item(8'h00, 16'h0000, 8'd255));
		send_item(load_item(6'd5, 8'hA5));
		send_item(start_item(8'h12, 16'h3456, 8'd4));
		send_item(rx_item(reg_ack_type, frame_seq, 7'd2));
		send_item(tick_item());
		send_item(rx_item(~reg_ack_type, frame_seq, 7'd3));
		send_item(rx_item(reg_ack_type, ~frame_seq, 7'd3));
		send_item(rx_item(reg_ack_type, frame_seq, 7'd3));
		// nothing pending, so these are dropped
		send_item(tick_item());
		send_item(rx_item(reg_ack_type, frame_seq, 7'd64));
		quiesce();
	endtask

	// one attempt, oversized length limit, zero timeout, zero attempts
	task automatic test_attempt_limits();
		set_register(swfs_pkg::CFG_ACK_TYPE, 16'h00FF);
		set_register(swfs_pkg::CFG_ACK_TIMEOUT, 16'd1);
		set_register(swfs_pkg::CFG_MAX_ATTEMPTS, 16'd1);
		set_register(swfs_pkg::CFG_MAX_LEN, 16'd63);
		send_item(start_item(8'h5A, 16'h8001, 8'd255));
		send_item(tick_item());
		quiesce();
		set_register(swfs_pkg::CFG_ACK_TIMEOUT, 16'd0);
		set_register(swfs_pkg::CFG_MAX_ATTEMPTS, 16'd2);
		set_register(swfs_pkg::CFG_MAX_LEN, 16'd62);
		send_item(start_item(8'hA5, 16'h7FFE, 8'd61));
		send_item(tick_item());
		send_item(tick_item());
		quiesce();
		set_register(swfs_pkg::CFG_MAX_ATTEMPTS, 16'd0);
		send_item(start_item(8'h01, 16'h0100, 8'd7));
		quiesce();
	endtask

	// header-only frames, longest timeout, most attempts
	task automatic test_header_only();
		set_register(swfs_pkg::CFG_MAX_LEN, 16'd0);
		set_register(swfs_pkg::CFG_MAX_ATTEMPTS, 16'd255);
		set_register(swfs_pkg::CFG_ACK_TIMEOUT, 16'hFFFF);
		send_item(start_item(8'h3C, 16'hC3C3, 8'd200));
		send_item(tick_item());
		send_item(tick_item());
		send_item(wrong_reply());
		send_item(ack_item());
		quiesce();
	endtask

	task automatic randomize_registers();
		case ($urandom_range(0, 3))
			0:       set_register(swfs_pkg::CFG_ACK_TYPE, 16'h0000);
			1:       set_register(swfs_pkg::CFG_ACK_TYPE, 16'h00FF);
			default: set_register(swfs_pkg::CFG_ACK_TYPE, 16'($urandom_range(0, 255)));
		endcase
		case ($urandom_range(0, 5))
			0:       set_register(swfs_pkg::CFG_ACK_TIMEOUT, 16'd0);
			1:       set_register(swfs_pkg::CFG_ACK_TIMEOUT, 16'hFFFF);
			default: set_register(swfs_pkg::CFG_ACK_TIMEOUT, 16'($urandom_range(1, 4)));
		endcase
		case ($urandom_range(0, 7))
			0:       set_register(swfs_pkg::CFG_MAX_ATTEMPTS, 16'd0);
			1:       set_register(swfs_pkg::CFG_MAX_ATTEMPTS, 16'd255);
			default: set_register(swfs_pkg::CFG_MAX_ATTEMPTS, 16'($urandom_range(1, 6)));
		endcase
		if ($urandom_range(0, 3) == 0)
			set_register(swfs_pkg::CFG_MAX_LEN, 16'($urandom_range(13, 63)));
		else
			set_register(swfs_pkg::CFG_MAX_LEN, 16'($urandom_range(0, 12)));
	endtask

	// loads, a start, then replies and ticks until done or out of events
	task automatic run_exchange();
		int n;
		repeat ($urandom_range(0, 2)) send_item(load_item(6'($urandom), 8'($urandom)));
		if ($urandom_range(0, 5) == 0)
			send_item(random_item());
		if (!sender_busy)
			send_item(start_item(8'($urandom), 16'($urandom), 8'($urandom_range(0, 255))));
		n = $urandom_range(1, 8);
		while (sender_busy && n > 0) begin
			n--;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_item(tick_item());
				4, 5:       send_item(wrong_reply());
				6:          send_item(rx_item(8'($urandom), 16'($urandom),
					7'($urandom_range(0, 2))));
				7:          send_item(random_item());
				default:    send_item(ack_item());
			endcase
		end
		if ($urandom_range(0, 7) == 0)
			wait_results();
	endtask

	task automatic test_random_exchanges();
		int target;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			steady_flow = (phase == RANDOM_PHASES - 1);
			randomize_registers();
			target = live_items + RANDOM_ITEMS / RANDOM_PHASES;
			run_exchange();
			// first exchange of a phase drains before more traffic
			wait_results();
			while (live_items < target)
				run_exchange();
			if (sender_busy)
				send_item(ack_item());
			quiesce();
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : test_sequence
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		cfg_en   = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		reset_sender_image();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_store_fill();
		test_reset_settings();
		test_attempt_limits();
		test_header_only();
		test_random_exchanges();

		quiesce();
		$display("%0d items sent (%0d acted on), %0d frames and %0d outcomes checked, %0d acked",
			items_sent, live_items, frames_seen, outcomes_seen, acks_seen);
		$display("covered register extremes, clipping, resends, give-ups and output stalls");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> stop_and_wait_frame_sender.f
src/swfs_pkg.sv
src/swfs_payload_ram.sv
src/swfs_frame_gen.sv
src/stop_and_wait_frame_sender.sv
verif/stop_and_wait_frame_sender_test.sv
